>>> sv/urlpd_pkg.sv
// Package for the URL percent decoder: word types, phase and status codes,
// and the hex digit lookup. No dependencies.
package urlpd_pkg;

  // Phase codes of the decoder state.
  localparam logic [1:0] PH_PASS    = 2'd0;
  localparam logic [1:0] PH_PERCENT = 2'd1;
  localparam logic [1:0] PH_FIRST   = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  // Status codes carried on the result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_TOO_SHORT = 2'd2;

  // Characters that the decoder recognizes.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  // One input word: a byte of the encoded string.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // One result word.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       end_of_string;
  } out_t;

  // Outcome of one decode step.
  typedef struct packed {
    logic       has_res;
    out_t       res;
    logic [1:0] phase;
    logic [7:0] held;
    logic [1:0] kept;
  } step_t;

  // Hex digit value in bits 3:0; bit 4 set when the byte is not a digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff = c - CH_ZERO;
      return {1'b0, diff[3:0]};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      diff = c - CH_UPPER_A;
      return {1'b0, diff[3:0] + HEX_TEN};
    end
    return 5'h10;
  endfunction

endpackage

>>> sv/urlpd_step.sv
// Combinational decode step of the URL percent decoder.
// Depends on urlpd_pkg for the word types, codes and hex lookup.
module urlpd_step (
  input  logic [1:0]     phase_i,
  input  logic [7:0]     held_i,
  input  logic [1:0]     kept_i,
  input  urlpd_pkg::in_t word_i,
  output urlpd_pkg::step_t step_o
);
  import urlpd_pkg::*;

  logic [4:0] hi_val;
  logic [4:0] lo_val;

  assign hi_val = hex_value(held_i);
  assign lo_val = hex_value(word_i.in_byte);

  // Next state and result for the current phase.
  always_comb begin
    step_o       = '0;
    step_o.phase = phase_i;
    step_o.held  = held_i;
    step_o.kept  = kept_i;
    case (phase_i)
      PH_PASS: begin
        if (word_i.in_byte == CH_PERCENT) begin
          if (word_i.in_last) begin
            step_o.has_res          = 1'b1;
            step_o.res.status       = ST_TOO_SHORT;
            step_o.res.end_of_string = 1'b1;
          end else begin
            step_o.phase = PH_PERCENT;
          end
        end else begin
          step_o.has_res           = 1'b1;
          step_o.res.has_byte      = 1'b1;
          step_o.res.out_byte      = word_i.in_byte;
          step_o.res.end_of_string = word_i.in_last;
        end
      end
      PH_PERCENT: begin
        if (word_i.in_last) begin
          step_o.has_res           = 1'b1;
          step_o.res.status        = ST_TOO_SHORT;
          step_o.res.end_of_string = 1'b1;
        end else begin
          step_o.held  = word_i.in_byte;
          step_o.phase = PH_FIRST;
        end
      end
      PH_FIRST: begin
        step_o.held = 8'd0;
        if (!hi_val[4] && !lo_val[4]) begin
          step_o.has_res           = 1'b1;
          step_o.res.has_byte      = 1'b1;
          step_o.res.out_byte      = {hi_val[3:0], lo_val[3:0]};
          step_o.res.end_of_string = word_i.in_last;
          step_o.phase             = PH_PASS;
        end else if (word_i.in_last) begin
          step_o.has_res           = 1'b1;
          step_o.res.status        = ST_INVALID;
          step_o.res.end_of_string = 1'b1;
        end else begin
          step_o.kept  = ST_INVALID;
          step_o.phase = PH_DISCARD;
        end
      end
      default: begin
        if (word_i.in_last) begin
          step_o.has_res           = 1'b1;
          step_o.res.status        = kept_i;
          step_o.res.end_of_string = 1'b1;
        end
      end
    endcase

    // The last byte of a string returns the state to its reset values.
    if (word_i.in_last) begin
      step_o.phase = PH_PASS;
      step_o.held  = 8'd0;
      step_o.kept  = ST_OK;
    end
  end

endmodule

>>> sv/url_percent_decoder_core.sv
// URL percent decoder: one input word per cycle, zero or one result word.
// A result is registered in the output register, or in the skid entry when the
// output is stalled. Input stalls while the skid entry is full; the step logic
// is combinational, and a two-entry output buffer absorbs output stalls.
// Reset: asynchronous, active low; clears phase, held digit, error and buffers.
// Depends on urlpd_pkg and urlpd_step.
module url_percent_decoder_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  urlpd_pkg::in_t  in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output urlpd_pkg::out_t out_word_o
);
  import urlpd_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [1:0] kept_q, kept_d;
  logic       main_valid_q, main_valid_d;
  out_t       main_q, main_d;
  logic       skid_valid_q, skid_valid_d;
  out_t       skid_q, skid_d;
  step_t      step;
  logic       in_fire;
  logic       out_fire;

  // Decode step for the word on the input.
  urlpd_step u_step (
    .phase_i (phase_q),
    .held_i  (held_q),
    .kept_i  (kept_q),
    .word_i  (in_word_i),
    .step_o  (step)
  );

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = main_valid_q;
  assign out_word_o  = main_q;
  assign out_fire    = main_valid_q && !out_stall_i;

  // Decoder state advances on each accepted word.
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    kept_d  = kept_q;
    if (in_fire) begin
      phase_d = step.phase;
      held_d  = step.held;
      kept_d  = step.kept;
    end
  end

  // Output register with a skid entry behind it.
  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire && step.has_res) begin
      if (!main_valid_q || out_fire) begin
        main_d       = step.res;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = step.res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PASS;
      held_q       <= 8'd0;
      kept_q       <= ST_OK;
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      held_q       <= held_d;
      kept_q       <= kept_d;
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // The skid entry is only filled behind a waiting output word.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry valid while output register empty");

  // The last byte of a string returns the decoder to pass-through.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_word_i.in_last) |=> (phase_q == PH_PASS && kept_q == ST_OK))
    else $error("decoder state not cleared after last byte");

  // A kept error only exists while discarding the rest of a string.
  a_kept_in_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_q != ST_OK) |-> (phase_q == PH_DISCARD))
    else $error("kept error outside discard phase");

  // An error status appears only on an end marker without a byte.
  a_error_on_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != ST_OK)
      |-> (out_word_o.end_of_string && !out_word_o.has_byte))
    else $error("error status on a non-marker word");

endmodule
